// ===== rtl/core/lse_pkg.sv =====
// Shared types and codes for the LIFO stack engine.
`timescale 1ns / 1ps

package lse_pkg;

   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_DUMP = 3'd1;
   localparam logic [2:0] CMD_PEEK = 3'd2;
   localparam logic [2:0] CMD_POP  = 3'd3;
   localparam logic [2:0] CMD_SWAP = 3'd4;

   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_DATA  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_SHORT = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   localparam int MIN_SWAP = 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PEEK,
      S_DUMP,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C
   } state_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_SECOND,
      RD_IDX_DEC
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_PUSH,
      WR_TOP_FROM_RD,
      WR_SECOND_FROM_HOLD
   } wr_sel_type;

   typedef struct packed {
      logic       mem_we;
      wr_sel_type wr_sel;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       idx_load;
      logic       idx_dec;
      logic       hold_load;
      logic       out_load;
      logic [2:0] out_status;
      logic       out_data_en;
      logic       out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic short_stack;
      logic idx_zero;
      logic slot_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/lse_ctrl.sv =====
// Command sequencer for the LIFO stack engine.
`timescale 1ns / 1ps

module lse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_cmd,
   input  lse_pkg::dp_stat_type stat,
   output lse_pkg::ctl_cmd_type ctl
);

   lse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lse_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         lse_pkg::S_IDLE: begin
            req_ready = stat.slot_free;
            if (req_valid && stat.slot_free) begin
               unique case (req_cmd)
                  lse_pkg::CMD_PUSH: begin
                     ctl.out_load = 1'b1;
                     ctl.out_last = 1'b1;
                     if (stat.full) begin
                        ctl.out_status = lse_pkg::ST_FULL;
                     end else begin
                        ctl.mem_we     = 1'b1;
                        ctl.wr_sel     = lse_pkg::WR_PUSH;
                        ctl.cnt_inc    = 1'b1;
                        ctl.out_status = lse_pkg::ST_DONE;
                     end
                  end
                  lse_pkg::CMD_DUMP: begin
                     if (stat.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_last   = 1'b1;
                        ctl.out_status = lse_pkg::ST_EMPTY;
                     end else begin
                        ctl.rd_en    = 1'b1;
                        ctl.rd_sel   = lse_pkg::RD_TOP;
                        ctl.idx_load = 1'b1;
                        state_in     = lse_pkg::S_DUMP;
                     end
                  end
                  lse_pkg::CMD_PEEK: begin
                     if (stat.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_last   = 1'b1;
                        ctl.out_status = lse_pkg::ST_EMPTY;
                     end else begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = lse_pkg::RD_TOP;
                        state_in   = lse_pkg::S_PEEK;
                     end
                  end
                  lse_pkg::CMD_POP: begin
                     ctl.out_load = 1'b1;
                     ctl.out_last = 1'b1;
                     if (stat.empty) begin
                        ctl.out_status = lse_pkg::ST_EMPTY;
                     end else begin
                        ctl.cnt_dec    = 1'b1;
                        ctl.out_status = lse_pkg::ST_DONE;
                     end
                  end
                  lse_pkg::CMD_SWAP: begin
                     if (stat.short_stack) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_last   = 1'b1;
                        ctl.out_status = lse_pkg::ST_SHORT;
                     end else begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = lse_pkg::RD_TOP;
                        state_in   = lse_pkg::S_SWAP_A;
                     end
                  end
                  default: begin
                     ctl.out_load   = 1'b1;
                     ctl.out_last   = 1'b1;
                     ctl.out_status = lse_pkg::ST_DONE;
                  end
               endcase
            end
         end
         lse_pkg::S_PEEK: begin
            if (stat.slot_free) begin
               ctl.out_load    = 1'b1;
               ctl.out_status  = lse_pkg::ST_DATA;
               ctl.out_data_en = 1'b1;
               ctl.out_last    = 1'b1;
               state_in        = lse_pkg::S_IDLE;
            end
         end
         lse_pkg::S_DUMP: begin
            if (stat.slot_free) begin
               ctl.out_load    = 1'b1;
               ctl.out_status  = lse_pkg::ST_DATA;
               ctl.out_data_en = 1'b1;
               ctl.out_last    = stat.idx_zero;
               if (stat.idx_zero) begin
                  state_in = lse_pkg::S_IDLE;
               end else begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_sel  = lse_pkg::RD_IDX_DEC;
                  ctl.idx_dec = 1'b1;
               end
            end
         end
         lse_pkg::S_SWAP_A: begin
            ctl.hold_load = 1'b1;
            ctl.rd_en     = 1'b1;
            ctl.rd_sel    = lse_pkg::RD_SECOND;
            state_in      = lse_pkg::S_SWAP_B;
         end
         lse_pkg::S_SWAP_B: begin
            ctl.mem_we = 1'b1;
            ctl.wr_sel = lse_pkg::WR_TOP_FROM_RD;
            state_in   = lse_pkg::S_SWAP_C;
         end
         lse_pkg::S_SWAP_C: begin
            // write repeats harmlessly while the result slot is busy
            ctl.mem_we = 1'b1;
            ctl.wr_sel = lse_pkg::WR_SECOND_FROM_HOLD;
            if (stat.slot_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_status = lse_pkg::ST_DONE;
               ctl.out_last   = 1'b1;
               state_in       = lse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lse_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/lse_dpath.sv =====
// Stack storage, fill count, dump index and result register.
`timescale 1ns / 1ps

module lse_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   req_value,
   input  lse_pkg::ctl_cmd_type ctl,
   output lse_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_data,
   output logic                 rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0]   mem [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   rd_data_ff;
   logic [31:0]   hold_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_data_ff;
   logic          rsp_last_ff;

   logic [AW-1:0] top_addr, second_addr, rd_addr, wr_addr;
   logic [31:0]   wr_data;
   logic [CW-1:0] count_m1, count_m2;

   assign count_m1    = count_ff - CW'(1);
   assign count_m2    = count_ff - CW'(2);
   assign top_addr    = count_m1[AW-1:0];
   assign second_addr = count_m2[AW-1:0];

   always_comb begin
      unique case (ctl.rd_sel)
         lse_pkg::RD_TOP:     rd_addr = top_addr;
         lse_pkg::RD_SECOND:  rd_addr = second_addr;
         lse_pkg::RD_IDX_DEC: rd_addr = idx_ff - AW'(1);
         default:             rd_addr = top_addr;
      endcase
   end

   always_comb begin
      unique case (ctl.wr_sel)
         lse_pkg::WR_PUSH: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = req_value;
         end
         lse_pkg::WR_TOP_FROM_RD: begin
            wr_addr = top_addr;
            wr_data = rd_data_ff;
         end
         lse_pkg::WR_SECOND_FROM_HOLD: begin
            wr_addr = second_addr;
            wr_data = hold_ff;
         end
         default: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = req_value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.hold_load) begin
         hold_ff <= rd_data_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_m1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.idx_load) begin
         idx_in = top_addr;
      end else if (ctl.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end
   end

   assign stat.slot_free   = !rsp_valid_ff || rsp_ready;
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.short_stack = (count_ff < CW'(lse_pkg::MIN_SWAP));
   assign stat.idx_zero    = (idx_ff == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_status_ff <= ctl.out_status;
         rsp_data_ff   <= ctl.out_data_en ? rd_data_ff : '0;
         rsp_last_ff   <= ctl.out_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_inc |-> !stat.full)
      else $error("push into full stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_dec |-> !stat.empty)
      else $error("pop from empty stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> stat.slot_free)
      else $error("result overwritten before delivery");

endmodule

// ===== rtl/core/lifo_stack_engine.sv =====
// Top level of the LIFO stack engine: sequencer plus storage datapath.
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------------
//   request  | req_valid / req_ready  | req_cmd, req_value
//   response | rsp_valid / rsp_ready  | rsp_status, rsp_data, rsp_last
//
// Push, pop and unknown commands answer from idle; peek reads the top, then answers.
// Swap holds the top, reads the second, writes both back crossed, then answers. Dump sends one
// word per cycle while the response is not held; the stack memory has one registered read port.
// Reset clears the fill count, the sequencer and the response valid; the
// memory is not cleared.
// A low rsp_ready holds a pending response and stalls the sequencer in any state that must load a new one.
`timescale 1ns / 1ps

module lifo_stack_engine #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic               rsp_last
);

   lse_pkg::ctl_cmd_type ctl;
   lse_pkg::dp_stat_type stat;

   lse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .ctl       (ctl)
   );

   lse_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== verif/tb_lifo_stack_engine.sv =====
// Testbench for the LIFO stack engine: directed and random commands against a local stack model.
`timescale 1ns / 1ps

module tb_lifo_stack_engine;

   localparam int STACK_DEPTH   = 64;
   localparam int CMD_CODES     = 8;
   localparam int STALL_CYCLES  = 150;
   localparam int DRAIN_CYCLES  = 16;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int UNWIND_KEEP   = 24;
   localparam int RANDOM_ITEMS  = 12;

   typedef struct {
      logic [2:0]         status;
      logic signed [31:0] data;
      logic               last;
   } rsp_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_cmd = lse_pkg::CMD_PUSH;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic               rsp_last;

   logic signed [31:0] stack_words [STACK_DEPTH];
   int                 stack_fill = 0;
   rsp_word_type       expected_rsp [$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int rcv_idle_pct   = 0;
   int stall_requests = 0;
   int stall_served   = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;

   lifo_stack_engine #(.DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   always #10 clock = ~clock;

   // Stack model: updates the local copy and queues the words this command returns.
   function automatic void stack_predict(input logic [2:0] cmd, input logic signed [31:0] value);
      logic signed [31:0] tmp;
      case (cmd)
         lse_pkg::CMD_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               expected_rsp.push_back('{lse_pkg::ST_FULL, '0, 1'b1});
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
               expected_rsp.push_back('{lse_pkg::ST_DONE, '0, 1'b1});
            end
         end
         lse_pkg::CMD_DUMP: begin
            if (stack_fill == 0) begin
               expected_rsp.push_back('{lse_pkg::ST_EMPTY, '0, 1'b1});
            end else begin
               for (int i = stack_fill - 1; i >= 0; i--)
                  expected_rsp.push_back('{lse_pkg::ST_DATA, stack_words[i], i == 0});
            end
         end
         lse_pkg::CMD_PEEK: begin
            if (stack_fill == 0)
               expected_rsp.push_back('{lse_pkg::ST_EMPTY, '0, 1'b1});
            else
               expected_rsp.push_back('{lse_pkg::ST_DATA, stack_words[stack_fill - 1], 1'b1});
         end
         lse_pkg::CMD_POP: begin
            if (stack_fill == 0) begin
               expected_rsp.push_back('{lse_pkg::ST_EMPTY, '0, 1'b1});
            end else begin
               stack_fill--;
               expected_rsp.push_back('{lse_pkg::ST_DONE, '0, 1'b1});
            end
         end
         lse_pkg::CMD_SWAP: begin
            if (stack_fill < lse_pkg::MIN_SWAP) begin
               expected_rsp.push_back('{lse_pkg::ST_SHORT, '0, 1'b1});
            end else begin
               tmp = stack_words[stack_fill - 1];
               stack_words[stack_fill - 1] = stack_words[stack_fill - 2];
               stack_words[stack_fill - 2] = tmp;
               expected_rsp.push_back('{lse_pkg::ST_DONE, '0, 1'b1});
            end
         end
         default: expected_rsp.push_back('{lse_pkg::ST_DONE, '0, 1'b1});
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge where the word is accepted.
   task automatic send_word(input logic [2:0] cmd, input logic signed [31:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_cmd   <= 3'($urandom);
         req_value <= $urandom;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      stack_predict(cmd, value);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Response side: random backpressure, or a long hold when one is requested.
   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left    <= STALL_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d data=%0d last=%0b",
                                      rsp_status, rsp_data, rsp_last));
         end else begin
            exp_w = expected_rsp.pop_front();
            if (rsp_status !== exp_w.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, exp_w.status));
            if (rsp_data !== exp_w.data)
               report_mismatch($sformatf("data %0d, want %0d", rsp_data, exp_w.data));
            if (rsp_last !== exp_w.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, exp_w.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_empty_stack();
      send_word(lse_pkg::CMD_POP, pick_value());
      send_word(lse_pkg::CMD_PEEK, pick_value());
      send_word(lse_pkg::CMD_DUMP, pick_value());
      send_word(lse_pkg::CMD_SWAP, pick_value());
   endtask

   task automatic test_basic_ops();
      send_word(lse_pkg::CMD_PUSH, 32'sh8000_0000);
      send_word(lse_pkg::CMD_SWAP, pick_value());
      send_word(lse_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
      send_word(lse_pkg::CMD_PEEK, '0);
      send_word(lse_pkg::CMD_SWAP, '0);
      send_word(lse_pkg::CMD_PEEK, '0);
      send_word(lse_pkg::CMD_DUMP, '0);
      send_word(lse_pkg::CMD_PUSH, '0);
      send_word(lse_pkg::CMD_PUSH, -32'sd1);
      send_word(lse_pkg::CMD_PUSH, 32'sh5A5A_A5A5);
      send_word(lse_pkg::CMD_DUMP, -32'sd1);
      send_word(lse_pkg::CMD_POP, -32'sd1);
      send_word(lse_pkg::CMD_PEEK, -32'sd1);
   endtask

   task automatic test_undefined_cmds();
      for (int c = int'(lse_pkg::CMD_SWAP) + 1; c < CMD_CODES; c++)
         send_word(3'(c), pick_value());
      send_word(lse_pkg::CMD_PEEK, '0);
   endtask

   // Drain, fill to the top under a long response hold, overflow, swap, peek and dump, then partly unwind.
   task automatic test_fill_and_overflow();
      int n;
      n = stack_fill;
      for (int i = 0; i < n; i++)
         send_word(lse_pkg::CMD_POP, pick_value());
      stall_requests++;
      for (int i = 0; i < STACK_DEPTH; i++)
         send_word(lse_pkg::CMD_PUSH, pick_value());
      send_word(lse_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
      send_word(lse_pkg::CMD_PUSH, 32'sh8000_0000);
      send_word(lse_pkg::CMD_SWAP, '0);
      send_word(lse_pkg::CMD_PEEK, '0);
      send_word(lse_pkg::CMD_DUMP, '0);
      for (int i = 0; i < STACK_DEPTH - UNWIND_KEEP; i++)
         send_word(lse_pkg::CMD_POP, '0);
   endtask

   task automatic test_random(input int count);
      int pick;
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (stack_fill < 4)
            pick = pick / 2;
         if (pick < 40)      cmd = lse_pkg::CMD_PUSH;
         else if (pick < 60) cmd = lse_pkg::CMD_POP;
         else if (pick < 72) cmd = lse_pkg::CMD_PEEK;
         else if (pick < 86) cmd = lse_pkg::CMD_SWAP;
         else if (pick < 94) cmd = lse_pkg::CMD_DUMP;
         else                cmd = 3'(int'(lse_pkg::CMD_SWAP) + 1 + $urandom_range(0, 2));
         send_word(cmd, pick_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      rcv_idle_pct  = 48;
      test_empty_stack();
      test_basic_ops();
      test_undefined_cmds();
      test_fill_and_overflow();
      test_random(RANDOM_ITEMS);

      send_idle_pct = 48;
      rcv_idle_pct  = 32;
      test_random(RANDOM_ITEMS);

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_random(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lse_pkg.sv
rtl/core/lse_ctrl.sv
rtl/core/lse_dpath.sv
rtl/core/lifo_stack_engine.sv
verif/tb_lifo_stack_engine.sv
